/* hdl/ajb_pkg.sv */
package ajb_pkg;

    localparam int WORD_W   = 32;
    localparam int CFG_W    = 7;
    localparam int FILL_W   = 7;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 3'd0,
        ST_POPPED    = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_REBUFFER  = 3'd4
    } t_status;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    typedef enum logic {
        CFG_INITIAL_TARGET = 1'b0,
        CFG_GROW_STEP      = 1'b1
    } t_cfg_idx;

    // Configuration write as seen by the control logic
    typedef struct packed {
        logic             we;
        t_cfg_idx         index;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

    // Ring memory access request for one item
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ring_op;

endpackage

/* hdl/ajb_ifs.sv */
interface ajb_item_if
    import ajb_pkg::*;
();
    logic              valid;
    logic              ready;
    t_mode             mode;
    logic [WORD_W-1:0] chunk_word;

    modport source (output valid, output mode, output chunk_word, input ready);
    modport sink   (input valid, input mode, input chunk_word, output ready);
endinterface

interface ajb_result_if
    import ajb_pkg::*;
();
    logic              valid;
    logic              ready;
    t_status           status;
    logic              data_valid;
    logic [WORD_W-1:0] chunk_out;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, output status, output data_valid, output chunk_out,
                    output fill_level, input ready);
    modport sink   (input valid, input status, input data_valid, input chunk_out,
                    input fill_level, output ready);
endinterface

interface ajb_cfg_if
    import ajb_pkg::*;
();
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/ajb_ring.sv */
module ajb_ring
    import ajb_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  t_ring_op          i_op,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_op.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_op.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/ajb_ctrl.sv */
module ajb_ctrl
    import ajb_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_mode             i_mode,
    input  t_cfg_wr           i_cfg,
    output t_ring_op          o_op,
    output logic [AW-1:0]     o_wr_addr,
    output logic [AW-1:0]     o_rd_addr,
    output t_status           o_status,
    output logic [FILL_W-1:0] o_fill_level
);

    // wide enough for a 7-bit register value, a counter, and their sum
    localparam int SW = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam logic [SW-1:0]   DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0]   DEPTH_C = CW'(DEPTH);
    localparam logic [AW:0]     DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [CFG_W-1:0] INIT_TARGET_RST = CFG_W'(32);
    localparam logic [CFG_W-1:0] GROW_STEP_RST   = CFG_W'(8);

    logic [AW-1:0]    r_rd_pos, n_rd_pos;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_recv, n_recv;
    logic [CW-1:0]    r_target, n_target;
    logic             r_rebuf, n_rebuf;
    logic [CFG_W-1:0] r_step, n_step;

    logic [AW:0]      wr_sum;
    logic [AW:0]      rd_next;
    logic [SW-1:0]    grow_sum;
    logic [CW-1:0]    grown_target;
    logic [CW-1:0]    cfg_target;
    logic [CW-1:0]    rst_target;
    logic [CW-1:0]    recv_inc;

    function automatic logic [CW-1:0] clamp_depth(input logic [SW-1:0] v);
        clamp_depth = (v > DEPTH_S) ? DEPTH_C : CW'(v);
    endfunction

    always_comb begin
        wr_sum       = (AW + 1)'(r_rd_pos) + (AW + 1)'(r_fill);
        rd_next      = (AW + 1)'(r_rd_pos) + (AW + 1)'(1);
        grow_sum     = SW'(r_target) + SW'(r_step);
        grown_target = clamp_depth(grow_sum);
        cfg_target   = clamp_depth(SW'(i_cfg.data));
        rst_target   = clamp_depth(SW'(INIT_TARGET_RST));
        recv_inc     = (r_recv < DEPTH_C) ? (r_recv + CW'(1)) : r_recv;
    end

    always_comb begin
        n_rd_pos  = r_rd_pos;
        n_fill    = r_fill;
        n_recv    = r_recv;
        n_target  = r_target;
        n_rebuf   = r_rebuf;
        n_step    = r_step;
        o_op      = '0;
        o_status  = ST_PUSHED;
        o_wr_addr = (wr_sum >= DEPTH_A) ? AW'(wr_sum - DEPTH_A) : AW'(wr_sum);
        o_rd_addr = r_rd_pos;

        if (i_accept) begin
            unique case (i_mode)
                MODE_PUSH: begin
                    if (r_fill == DEPTH_C) begin
                        // full: drop the chunk, cut back to target
                        n_fill   = r_target;
                        o_status = ST_OVERFLOW;
                    end else begin
                        o_op.wr_en = 1'b1;
                        n_fill     = r_fill + CW'(1);
                        n_recv     = recv_inc;
                        if (recv_inc >= r_target) begin
                            n_rebuf = 1'b0;
                        end
                        o_status = ST_PUSHED;
                    end
                end
                MODE_POP: begin
                    if (r_fill == '0) begin
                        if (!r_rebuf) begin
                            n_recv   = '0;
                            n_target = grown_target;
                        end
                        n_rebuf  = 1'b1;
                        o_status = ST_UNDERFLOW;
                    end else if (r_rebuf) begin
                        o_status = ST_REBUFFER;
                    end else begin
                        o_op.rd_en = 1'b1;
                        n_fill     = r_fill - CW'(1);
                        n_rd_pos   = (rd_next >= DEPTH_A) ? '0 : AW'(rd_next);
                        o_status   = ST_POPPED;
                    end
                end
                default: ;
            endcase
        end

        if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_INITIAL_TARGET: n_target = cfg_target;
                CFG_GROW_STEP:      n_step   = i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_fill_level = FILL_W'(n_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos <= '0;
            r_fill   <= '0;
            r_recv   <= '0;
            r_target <= rst_target;
            r_rebuf  <= 1'b1;
            r_step   <= GROW_STEP_RST;
        end else begin
            r_rd_pos <= n_rd_pos;
            r_fill   <= n_fill;
            r_recv   <= n_recv;
            r_target <= n_target;
            r_rebuf  <= n_rebuf;
            r_step   <= n_step;
        end
    end

endmodule

/* hdl/adaptive_jitter_buffer.sv */
// Adaptive jitter buffer: a ring of DEPTH 32-bit chunk words with push and pop
// items on one input channel and one result per item on the output channel.
// The block takes one item per clock while the input is not stalled; a result
// passes through the read stage, which waits for the registered ring read of a
// pop, and then through the output register. Counters (read position, fill,
// received count, target, rebuffering flag) update in the cycle an item is
// taken, so the next item sees them at once; a push writes its entry in that
// cycle, and a later pop reads it no earlier than the next cycle, so the
// ring needs no forwarding. The input stalls only while both the read stage
// and the output register hold results that the sink has not taken. Entries
// never pushed are never read. Configuration writes are accepted every cycle;
// writing initial_target also reloads the current target, clamped to DEPTH.
module adaptive_jitter_buffer
    import ajb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ajb_item_if.sink    i_item,
    ajb_result_if.source o_result,
    ajb_cfg_if.sink     i_cfg
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic              item_xfer;
    logic              s1_advance;
    t_cfg_wr           cfg_wr;
    t_ring_op          ring_op;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    t_status           step_status;
    logic [FILL_W-1:0] step_fill;

    // read stage: result waits here for the ring read data
    logic              r_s1_valid;
    t_status           r_s1_status;
    logic [FILL_W-1:0] r_s1_fill;

    // output register
    logic              r_out_valid;
    t_status           r_out_status;
    logic              r_out_dvalid;
    logic [WORD_W-1:0] r_out_chunk;
    logic [FILL_W-1:0] r_out_fill;

    // advance the read stage whenever the output register is free or drains
    assign s1_advance   = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_s1_valid || s1_advance;
    assign item_xfer    = i_item.valid && i_item.ready;

    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.we    = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    ajb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (item_xfer),
        .i_mode       (i_item.mode),
        .i_cfg        (cfg_wr),
        .o_op         (ring_op),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_status     (step_status),
        .o_fill_level (step_fill)
    );

    ajb_ring #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_op      (ring_op),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_item.chunk_word),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control for the read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (item_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload: capture the step result, then merge in the ring data
    always_ff @(posedge i_clk) begin
        if (item_xfer) begin
            r_s1_status <= step_status;
            r_s1_fill   <= step_fill;
        end
        if (s1_advance && r_s1_valid) begin
            r_out_status <= r_s1_status;
            r_out_dvalid <= (r_s1_status == ST_POPPED);
            r_out_chunk  <= (r_s1_status == ST_POPPED) ? rd_data : '0;
            r_out_fill   <= r_s1_fill;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_out_status;
    assign o_result.data_valid = r_out_dvalid;
    assign o_result.chunk_out  = r_out_chunk;
    assign o_result.fill_level = r_out_fill;

    // a popped chunk and only a popped chunk carries data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.data_valid == (o_result.status == ST_POPPED)))
        else $error("data_valid does not match popped status");

    // anything but a pop delivers a zero chunk
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.data_valid) |-> (o_result.chunk_out == '0))
        else $error("chunk_out not zero without data");

    // input stalls only when both result slots are held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r_s1_valid && r_out_valid && !o_result.ready))
        else $error("input stalled with a free result slot");

    // an accepted item reaches the output register on the next advance
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_xfer && !r_out_valid) |=> ##1 r_out_valid)
        else $error("accepted item did not reach the output");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ajb_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 140;

    // One result of the block, and the directed stimulus rows
    typedef struct packed {
        t_status           status;
        logic              data_valid;
        logic [WORD_W-1:0] chunk;
        logic [FILL_W-1:0] fill;
    } t_jb_result;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_mode             mode;
        logic [WORD_W-1:0] word;
        t_cfg_idx          idx;
        logic [CFG_W-1:0]  cfg_data;
        logic              typed;
        t_jb_result        want;
    } t_dir_row;

    localparam int DIR_ROWS = 20;

    // Directed rows: typed expectations where the answer is obvious, the rest
    // goes through the buffer predictor.
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // Reset config (target 32, step 8): underflow while already rebuffering
        '{ROW_ITEM, MODE_POP,  32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_UNDERFLOW, 1'b0, 32'h0, 7'd0}},
        '{ROW_ITEM, MODE_PUSH, 32'hFFFF_FFFF, CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_PUSHED,    1'b0, 32'h0, 7'd1}},
        // Data held but still rebuffering
        '{ROW_ITEM, MODE_POP,  32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_REBUFFER,  1'b0, 32'h0, 7'd1}},
        '{ROW_CFG,  MODE_PUSH, 32'h0,         CFG_INITIAL_TARGET, 7'd1,   1'b0, '0},
        '{ROW_ITEM, MODE_PUSH, 32'h0000_0000, CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_PUSHED,    1'b0, 32'h0, 7'd2}},
        '{ROW_ITEM, MODE_POP,  32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_POPPED,    1'b1, 32'hFFFF_FFFF, 7'd1}},
        '{ROW_ITEM, MODE_POP,  32'hFFFF_FFFF, CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_POPPED,    1'b1, 32'h0, 7'd0}},
        // Underflow out of playback: target grows to 9
        '{ROW_ITEM, MODE_POP,  32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_UNDERFLOW, 1'b0, 32'h0, 7'd0}},
        '{ROW_ITEM, MODE_PUSH, 32'hAAAA_AAAA, CFG_INITIAL_TARGET, 7'd0,   1'b0, '0},
        '{ROW_ITEM, MODE_POP,  32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b0, '0},
        '{ROW_CFG,  MODE_PUSH, 32'h0,         CFG_GROW_STEP,      7'd127, 1'b0, '0},
        // Zero target: the next push ends rebuffering
        '{ROW_CFG,  MODE_PUSH, 32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b0, '0},
        '{ROW_ITEM, MODE_PUSH, 32'h5555_5555, CFG_INITIAL_TARGET, 7'd0,   1'b0, '0},
        '{ROW_ITEM, MODE_POP,  32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_POPPED,    1'b1, 32'hAAAA_AAAA, 7'd1}},
        '{ROW_ITEM, MODE_POP,  32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_POPPED,    1'b1, 32'h5555_5555, 7'd0}},
        // Growth of 127 saturates the target at DEPTH
        '{ROW_ITEM, MODE_POP,  32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b1,
          '{ST_UNDERFLOW, 1'b0, 32'h0, 7'd0}},
        // Register value beyond DEPTH is clamped on load
        '{ROW_CFG,  MODE_PUSH, 32'h0,         CFG_INITIAL_TARGET, 7'd127, 1'b0, '0},
        '{ROW_CFG,  MODE_PUSH, 32'h0,         CFG_GROW_STEP,      7'd0,   1'b0, '0},
        '{ROW_ITEM, MODE_PUSH, 32'h1234_5678, CFG_INITIAL_TARGET, 7'd0,   1'b0, '0},
        '{ROW_ITEM, MODE_POP,  32'h0,         CFG_INITIAL_TARGET, 7'd0,   1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    ajb_item_if   item_ch ();
    ajb_result_if result_ch ();
    ajb_cfg_if    cfg_ch ();

    adaptive_jitter_buffer #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state: a private copy of the ring, counters and registers
    logic [WORD_W-1:0] ring_copy [DEPTH];
    int                rd_pos;
    int                fill_cnt;
    int                recv_cnt;
    int                target_lvl;
    bit                rebuffering;
    int                reg_init_target;
    int                reg_grow_step;

    t_jb_result        expected_results [$];
    t_jb_result        predicted;
    t_jb_result        got;
    t_jb_result        want;

    // Handoff from the sender: a typed expectation for the item on the bus
    bit                pending_typed;
    t_jb_result        pending_want;

    bit                src_calm;
    bit                sink_calm;
    int                fail_count;
    int                cycle_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Drive every input to a known value before the first edge
    initial begin
        i_rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.mode         = MODE_PUSH;
        item_ch.chunk_word   = '0;
        result_ch.ready      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_INITIAL_TARGET;
        cfg_ch.data          = '0;
        pending_typed        = 1'b0;
        pending_want         = '0;
        src_calm             = 1'b0;
        sink_calm            = 1'b0;
        fail_count           = 0;
        rd_pos               = 0;
        fill_cnt             = 0;
        recv_cnt             = 0;
        reg_init_target      = 32;
        reg_grow_step        = 8;
        target_lvl           = 32;
        rebuffering          = 1'b1;
        for (int i = 0; i < DEPTH; i++) ring_copy[i] = '0;
    end

    function automatic int cap_depth(int v);
        return (v > DEPTH) ? DEPTH : v;
    endfunction

    // Advance the buffer predictor by one push or pop; return its result
    function automatic t_jb_result buffer_step(t_mode m, logic [WORD_W-1:0] w);
        t_jb_result r;
        r.status     = ST_PUSHED;
        r.data_valid = 1'b0;
        r.chunk      = '0;
        if (m == MODE_PUSH) begin
            if (fill_cnt >= DEPTH) begin
                // Full ring: drop the chunk and cut back to the target
                fill_cnt = target_lvl;
                r.status = ST_OVERFLOW;
            end else begin
                ring_copy[(rd_pos + fill_cnt) % DEPTH] = w;
                fill_cnt++;
                if (recv_cnt < DEPTH) recv_cnt++;
                if (recv_cnt >= target_lvl) rebuffering = 1'b0;
            end
        end else begin
            if (fill_cnt == 0) begin
                // Only a fresh underrun restarts the count and grows the target
                if (!rebuffering) begin
                    recv_cnt   = 0;
                    target_lvl = cap_depth(target_lvl + reg_grow_step);
                end
                rebuffering = 1'b1;
                r.status    = ST_UNDERFLOW;
            end else if (rebuffering) begin
                r.status = ST_REBUFFER;
            end else begin
                r.chunk      = ring_copy[rd_pos];
                r.data_valid = 1'b1;
                fill_cnt--;
                rd_pos       = (rd_pos + 1) % DEPTH;
                r.status     = ST_POPPED;
            end
        end
        r.fill = FILL_W'(fill_cnt);
        return r;
    endfunction

    task automatic report_field(string name, logic [WORD_W-1:0] exp_v,
                                logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Sample all three channels at the rising edge. Check the result
    // transfer first, then predict the item transfer of the same edge; a
    // result never belongs to an item taken in the same cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got = '{result_ch.status, result_ch.data_valid,
                        result_ch.chunk_out, result_ch.fill_level};
                if (expected_results.size() == 0) begin
                    $display("%0d ns: result with nothing pending, actual %0d/%0d/0x%0h/%0d",
                             $time, got.status, got.data_valid, got.chunk, got.fill);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    report_field("status",     WORD_W'(want.status),     WORD_W'(got.status));
                    report_field("data_valid", WORD_W'(want.data_valid), WORD_W'(got.data_valid));
                    report_field("chunk_out",  want.chunk,               got.chunk);
                    report_field("fill_level", WORD_W'(want.fill),       WORD_W'(got.fill));
                end
            end
            if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
                predicted = buffer_step(item_ch.mode, item_ch.chunk_word);
                expected_results.push_back(pending_typed ? pending_want : predicted);
            end
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
                if (cfg_ch.index == CFG_INITIAL_TARGET) begin
                    // Writing the target register reloads the live target
                    reg_init_target = int'(cfg_ch.data);
                    target_lvl      = cap_depth(reg_init_target);
                end else begin
                    reg_grow_step = int'(cfg_ch.data);
                end
            end
        end
    end

    // Drop valid for a random gap unless the source is calm, then hold the item until the transfer.
    // Return at a falling edge with valid still high, so a back-to-back
    // item only swaps the payload.
    task automatic send_item(t_mode m, logic [WORD_W-1:0] w, bit typed,
                             t_jb_result exp_r);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pending_typed      = typed;
        pending_want       = exp_r;
        item_ch.mode       = m;
        item_ch.chunk_word = w;
        item_ch.valid      = 1'b1;
        @(posedge i_clk);
        while (item_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every outstanding result, plus pipeline slack
    task automatic wait_drained();
        item_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_random(t_mode m);
        send_item(m, $urandom, 1'b0, '0);
    endtask

    // Mostly playback-like traffic: bursts of pushes then pops, floods that
    // overrun the ring, drains that run it dry, and some random noise.
    task automatic run_traffic(int budget);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                n = $urandom_range(1, 24);
                repeat (n) send_random(MODE_PUSH);
                sent += n;
                n = $urandom_range(1, 24);
                repeat (n) send_random(MODE_POP);
                sent += n;
            end else if (pick < 67) begin
                n = DEPTH + $urandom_range(1, 3);
                repeat (n) send_random(MODE_PUSH);
                sent += n;
            end else if (pick < 77) begin
                n = DEPTH + $urandom_range(1, 3);
                repeat (n) send_random(MODE_POP);
                sent += n;
            end else begin
                n = $urandom_range(1, 12);
                repeat (n) send_random(t_mode'($urandom_range(0, 1)));
                sent += n;
            end
        end
    endtask

    // Result sink: stall a random number of cycles per result
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready = 1'b1;
            @(posedge i_clk);
            while (result_ch.valid !== 1'b1) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Watchdog: end a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int phase_init [PHASES];
        int phase_grow [PHASES];
        phase_init = '{1, 64, 127, 0, 0};
        phase_grow = '{0, 64, 127, 1, 0};
        phase_init[PHASES-1] = $urandom_range(1, 64);
        phase_grow[PHASES-1] = $urandom_range(0, 64);

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk the directed table; registers change only with the block idle
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                wait_drained();
                write_cfg(DIRECTED[i].idx, DIRECTED[i].cfg_data);
            end else begin
                send_item(DIRECTED[i].mode, DIRECTED[i].word, DIRECTED[i].typed,
                          DIRECTED[i].want);
            end
        end

        // Random phases, each under its own register setting and idling mix
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_cfg(CFG_INITIAL_TARGET, CFG_W'(phase_init[p]));
            write_cfg(CFG_GROW_STEP, CFG_W'(phase_grow[p]));
            src_calm  = (p == 1) || (p == 3);
            sink_calm = (p == 2) || (p == 3);
            run_traffic(PHASE_ITEMS);
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/ajb_pkg.sv
hdl/ajb_ifs.sv
hdl/ajb_ring.sv
hdl/ajb_ctrl.sv
hdl/adaptive_jitter_buffer.sv
tb/sv/tb_top.sv
